FILE: rtl/drop_tail_packet_fifo_core_assert.svh
// ----------------------------------------------------------------------------
// Drop-tail packet FIFO assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DROP_TAIL_PACKET_FIFO_CORE_ASSERT_SVH
`define DROP_TAIL_PACKET_FIFO_CORE_ASSERT_SVH

`ifndef SYNTH

`define DTPF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define DTPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DTPF_ASSERT_NOW(label, ante, cons)

`define DTPF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/dtpf_pkg.sv
// ----------------------------------------------------------------------------
// Drop-tail packet FIFO package
// Sizes, command codes, queue types and ring index helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dtpf_pkg;

    localparam int DEPTH        = 32;
    localparam int IDX_W        = $clog2(DEPTH + 1);
    localparam int LEN_W        = 6;
    localparam int CAP_W        = 6;
    localparam int HANDLE_W     = 32;
    localparam int DROP_W       = 32;
    localparam int RESULT_LIMIT = 32;
    localparam int CNT_W        = $clog2(RESULT_LIMIT);

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_PULL  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [HANDLE_W-1:0] handle;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } fq_t;

    function automatic logic [IDX_W-1:0] dtpf_advance(input logic [IDX_W-1:0] idx,
                                                      input logic [IDX_W-1:0] cap);
        logic [IDX_W:0] n;
        logic [IDX_W:0] ring;
        n    = {1'b0, idx} + 1'b1;
        ring = {1'b0, cap} + 1'b1;
        return (n >= ring) ? '0 : n[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] dtpf_len(input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W-1:0] tail,
                                                  input logic [IDX_W-1:0] cap);
        logic [IDX_W:0] sum;
        if (tail >= head) begin
            sum = {1'b0, tail} - {1'b0, head};
        end else begin
            sum = {1'b0, tail} + {1'b0, cap} + 1'b1 - {1'b0, head};
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dtpf_front.sv
// ----------------------------------------------------------------------------
// Drop-tail packet FIFO front end
// Accepts requests, decodes the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpf_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    command,
    input  wire logic [dtpf_pkg::HANDLE_W-1:0] packet_handle,
    output dtpf_pkg::fq_t                      fq,
    input  wire logic                          q_pop
);
    import dtpf_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    item_t      in_item;

    assign in_stall     = (count_reg == 2'd2);
    assign push         = in_valid && !in_stall;
    assign pop          = q_pop && (count_reg != 2'd0);
    assign in_item.cmd  = cmd_t'(command);
    assign in_item.handle = packet_handle;
    assign fq.valid     = (count_reg != 2'd0);
    assign fq.item      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dtpf_back.sv
// ----------------------------------------------------------------------------
// Drop-tail packet FIFO back end
// Executes queued requests on the handle ring and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "drop_tail_packet_fifo_core_assert.svh"

module dtpf_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dtpf_pkg::fq_t                 fq,
    output logic                               q_pop,
    input  wire logic                          cfg_valid,
    input  wire logic [dtpf_pkg::CAP_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               handle_valid,
    output logic [dtpf_pkg::HANDLE_W-1:0]      handle_out,
    output logic                               out_port,
    output logic [dtpf_pkg::LEN_W-1:0]         queue_length,
    output logic [dtpf_pkg::LEN_W-1:0]         high_water,
    output logic [dtpf_pkg::DROP_W-1:0]        drop_count,
    output logic                               last
);
    import dtpf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PULL  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [IDX_W-1:0]    tail_reg;
    logic [IDX_W-1:0]    tail_next;
    logic [IDX_W-1:0]    cap_reg;
    logic [IDX_W-1:0]    cap_next;
    logic [LEN_W-1:0]    hw_reg;
    logic [LEN_W-1:0]    hw_next;
    logic [DROP_W-1:0]   drops_reg;
    logic [DROP_W-1:0]   drops_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;

    logic [HANDLE_W-1:0] slot_mem [DEPTH + 1];
    logic [HANDLE_W-1:0] rd_data_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic                mem_rd;
    logic [IDX_W-1:0]    mem_raddr;

    logic                out_valid_reg;
    logic                handle_valid_reg;
    logic [HANDLE_W-1:0] handle_out_reg;
    logic                out_port_reg;
    logic [LEN_W-1:0]    queue_length_reg;
    logic [LEN_W-1:0]    high_water_reg;
    logic [DROP_W-1:0]   drop_count_reg;
    logic                last_reg;

    logic                emit;
    logic                e_valid;
    logic [HANDLE_W-1:0] e_handle;
    logic                e_port;
    logic                e_last;
    logic [LEN_W-1:0]    e_len;
    logic                out_free;
    logic [IDX_W-1:0]    adv_idx;
    logic [IDX_W-1:0]    new_len;
    logic                fin;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cap_next   = cap_reg;
        hw_next    = hw_reg;
        drops_next = drops_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = tail_reg;
        mem_rd     = 1'b0;
        mem_raddr  = head_reg;
        emit       = 1'b0;
        e_valid    = 1'b0;
        e_handle   = '0;
        e_port     = 1'b0;
        e_last     = 1'b1;
        adv_idx    = '0;
        new_len    = '0;
        fin        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (fq.valid && out_free)
                begin
                    q_pop = 1'b1;
                    case (fq.item.cmd)
                        CMD_PUSH:
                        begin
                            adv_idx = dtpf_advance(tail_reg, cap_reg);
                            emit    = 1'b1;
                            if (adv_idx != head_reg)
                            begin
                                mem_we    = 1'b1;
                                tail_next = adv_idx;
                                new_len   = dtpf_len(head_reg, adv_idx, cap_reg);
                                if (LEN_W'(new_len) > hw_reg)
                                begin
                                    hw_next = LEN_W'(new_len);
                                end
                            end
                            else
                            begin
                                drops_next = drops_reg + 1'b1;
                                e_valid    = 1'b1;
                                e_handle   = fq.item.handle;
                                e_port     = 1'b1;
                            end
                        end
                        CMD_PULL:
                        begin
                            if (head_reg != tail_reg)
                            begin
                                mem_rd     = 1'b1;
                                state_next = ST_PULL;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        CMD_RESET:
                        begin
                            drops_next = '0;
                            hw_next    = LEN_W'(dtpf_len(head_reg, tail_reg, cap_reg));
                            emit       = 1'b1;
                        end
                        CMD_FLUSH:
                        begin
                            if (head_reg != tail_reg)
                            begin
                                mem_rd     = 1'b1;
                                cnt_next   = '0;
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_PULL:
            begin
                if (out_free)
                begin
                    head_next  = dtpf_advance(head_reg, cap_reg);
                    emit       = 1'b1;
                    e_valid    = 1'b1;
                    e_handle   = rd_data_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    adv_idx   = dtpf_advance(head_reg, cap_reg);
                    head_next = adv_idx;
                    fin       = (adv_idx == tail_reg) ||
                                (cnt_reg == CNT_W'(RESULT_LIMIT - 1));
                    emit      = 1'b1;
                    e_valid   = 1'b1;
                    e_handle  = rd_data_reg;
                    e_port    = 1'b1;
                    e_last    = fin;
                    if (fin)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_rd    = 1'b1;
                        mem_raddr = adv_idx;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        e_len = LEN_W'(dtpf_len(head_next, tail_next, cap_reg));

        // A capacity write counts only while the ring is empty.
        if (cfg_valid && (head_reg == tail_reg))
        begin
            cap_next  = (cfg_data > CAP_W'(DEPTH)) ? IDX_W'(DEPTH) : IDX_W'(cfg_data);
            head_next = '0;
            tail_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cap_reg       <= IDX_W'(DEPTH);
            hw_reg        <= '0;
            drops_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cap_reg   <= cap_next;
            hw_reg    <= hw_next;
            drops_reg <= drops_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            handle_valid_reg <= e_valid;
            handle_out_reg   <= e_handle;
            out_port_reg     <= e_port;
            queue_length_reg <= e_len;
            high_water_reg   <= hw_next;
            drop_count_reg   <= drops_next;
            last_reg         <= e_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= fq.item.handle;
        end
        if (mem_rd)
        begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign handle_valid = handle_valid_reg;
    assign handle_out   = handle_out_reg;
    assign out_port     = out_port_reg;
    assign queue_length = queue_length_reg;
    assign high_water   = high_water_reg;
    assign drop_count   = drop_count_reg;
    assign last         = last_reg;

    `DTPF_ASSERT_NOW(a_len_in_cap, 1'b1, dtpf_len(head_reg, tail_reg, cap_reg) <= cap_reg)
    `DTPF_ASSERT_NOW(a_idx_in_ring, 1'b1, (head_reg <= cap_reg) && (tail_reg <= cap_reg))
    `DTPF_ASSERT_NOW(a_flush_nonempty, state_reg == ST_FLUSH, head_reg != tail_reg)
    `DTPF_ASSERT_NOW(a_pop_in_idle, q_pop, state_reg == ST_IDLE)
    `DTPF_ASSERT_NEXT(a_pull_reads, (state_reg == ST_IDLE) && (state_next == ST_PULL),
                      state_reg == ST_PULL)

endmodule

`default_nettype wire

FILE: rtl/drop_tail_packet_fifo_core.sv
// ----------------------------------------------------------------------------
// Drop-tail packet FIFO core
// Queue of packet handles with tail drop, drop counting and flush to drop port.
// ----------------------------------------------------------------------------
// Push and reset-counts requests complete in ST_IDLE as they are popped. A
// pull that finds a handle or a flush first reads the registered read port of
// the slot memory, then emits from ST_PULL or ST_FLUSH. A two-entry request
// queue lets new requests arrive while results wait on out_stall.
`default_nettype none

module drop_tail_packet_fifo_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    command,
    input  wire logic [dtpf_pkg::HANDLE_W-1:0] packet_handle,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dtpf_pkg::CAP_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               handle_valid,
    output logic [dtpf_pkg::HANDLE_W-1:0]      handle_out,
    output logic                               out_port,
    output logic [dtpf_pkg::LEN_W-1:0]         queue_length,
    output logic [dtpf_pkg::LEN_W-1:0]         high_water,
    output logic [dtpf_pkg::DROP_W-1:0]        drop_count,
    output logic                               last
);
    import dtpf_pkg::*;

    fq_t  fq;
    logic q_pop;

    assign cfg_ready = 1'b1;

    dtpf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .packet_handle (packet_handle),
        .fq            (fq),
        .q_pop         (q_pop)
    );

    dtpf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fq           (fq),
        .q_pop        (q_pop),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .handle_valid (handle_valid),
        .handle_out   (handle_out),
        .out_port     (out_port),
        .queue_length (queue_length),
        .high_water   (high_water),
        .drop_count   (drop_count),
        .last         (last)
    );

endmodule

`default_nettype wire
